// ===== rtl/core/frequency_admission_cache_policy_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers for the cache policy RTL.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ADMISSION_CACHE_POLICY_ASSERT_SVH
`define FREQUENCY_ADMISSION_CACHE_POLICY_ASSERT_SVH
`ifndef SYNTHESIS
`define FAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FAC_ASSERT(lbl, prop, msg)
`define FAC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/fac_pkg.sv =====
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types for the frequency admission cache policy.
// ----------------------------------------------------------------------------
package fac_pkg;

  // operation broadcast to every list cell
  typedef enum logic [1:0] {
    OP_NOP,
    OP_HIT,   // re-sort the matching entry to its new place
    OP_INS,   // sorted insert of a new entry
    OP_SHL    // drop the head, all entries move one place down
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ADMIT,
    ST_DONE
  } state_t;

  localparam int CFG_W      = 7;
  localparam int CAP_RESET  = 64;
  localparam int IN_OBJ_W   = 8;
  localparam int OUT_DATA_W = 40;

endpackage

// ===== rtl/core/fac_cell.sv =====
// ----------------------------------------------------------------------------
// fac_cell
// One place of the ordered resident list: object index and its count.
// ----------------------------------------------------------------------------
module fac_cell #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 16
) (
  input  logic              clk,
  input  fac_pkg::cell_op_t op,
  input  logic [IDX_W-1:0]  key,
  input  logic [CNT_W-1:0]  key_cnt,
  input  logic              vld,
  input  logic              is_first,
  input  logic [IDX_W-1:0]  left_obj,
  input  logic [CNT_W-1:0]  left_cnt,
  input  logic              left_le,
  input  logic [IDX_W-1:0]  right_obj,
  input  logic [CNT_W-1:0]  right_cnt,
  input  logic              right_le,
  input  logic              match_in,
  output logic              match_out,
  output logic              le,
  output logic [IDX_W-1:0]  obj,
  output logic [CNT_W-1:0]  cnt
);
  import fac_pkg::*;

  logic [IDX_W-1:0] obj_r, obj_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             match_here;

  assign le         = vld && (cnt_r <= key_cnt);
  assign match_here = vld && (obj_r == key);
  assign match_out  = match_in | match_here;
  assign obj        = obj_r;
  assign cnt        = cnt_r;

  always_comb begin
    obj_nxt = obj_r;
    cnt_nxt = cnt_r;
    case (op)
      OP_HIT: begin
        // entries past the moved one close the gap until the new place
        if (match_out) begin
          if (right_le) begin
            obj_nxt = right_obj;
            cnt_nxt = right_cnt;
          end else if (match_here || le) begin
            obj_nxt = key;
            cnt_nxt = key_cnt;
          end
        end
      end
      OP_INS: begin
        if (!le) begin
          if (is_first || left_le) begin
            obj_nxt = key;
            cnt_nxt = key_cnt;
          end else begin
            obj_nxt = left_obj;
            cnt_nxt = left_cnt;
          end
        end
      end
      OP_SHL: begin
        obj_nxt = right_obj;
        cnt_nxt = right_cnt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    obj_r <= obj_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ===== rtl/core/fac_count_mem.sv =====
// ----------------------------------------------------------------------------
// fac_count_mem
// Per-object request counts, reading zero until first written.
// ----------------------------------------------------------------------------
module fac_count_mem #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8,
  parameter int CNT_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [CNT_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [CNT_W-1:0] wr_data
);
  logic [CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [CNT_W-1:0] data_r;
  logic             data_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      data_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        data_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = data_vld_r ? data_r : '0;

endmodule

// ===== rtl/core/frequency_admission_cache_policy.sv =====
// ----------------------------------------------------------------------------
// frequency_admission_cache_policy
// Frequency-based admission and least-requested eviction for an object cache.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (lsb first)                       | tuser
//  in_     | in  | object_index[7:0]                              | -
//  out_    | out | was_resident, admitted, evicted, victim_index,  | -
//          |     | request_count, resident_count                  |
//  cfg_    | in  | capacity_objects[6:0]                          | -
//
//  One beat passes through accept, count lookup, admit (used only after
//  an eviction) and result load; the count RAM read port and the single
//  cell-chain update per cycle set these steps.
//  Reset clears counts via per-entry valid bits at once; no clearing pass.
//  A result waiting on out_tready holds the block in its last state; the
//  next beat is taken as soon as the result register is loaded.
// ----------------------------------------------------------------------------
`include "frequency_admission_cache_policy_assert.svh"

module frequency_admission_cache_policy #(
  parameter int NUM_OBJECTS  = 256,
  parameter int MAX_RESIDENT = 64,
  parameter int COUNT_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fac_pkg::IN_OBJ_W-1:0]     in_tdata,    // object_index[7:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // was_resident[0], admitted[1], evicted[2], victim_index[10:3],
  // request_count[26:11], resident_count[33:27], zero fill [39:34]
  output logic [fac_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [fac_pkg::CFG_W-1:0]        cfg_wr_data  // capacity_objects
);
  import fac_pkg::*;

  localparam int IDX_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int TOT_W = $clog2(MAX_RESIDENT + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // control
  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] cap_r;
  logic [TOT_W-1:0] cap_eff;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [NUM_OBJECTS-1:0] flag_r, flag_nxt;

  // per-beat working registers
  logic [IDX_W-1:0]      idx_r, idx_in;
  logic [COUNT_BITS-1:0] c_r, c_nxt, c_rd;
  logic                  was_r, was_nxt;
  logic                  adm_r, adm_nxt;
  logic                  evc_r, evc_nxt;
  logic [IDX_W-1:0]      vic_r, vic_nxt;

  // result register
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_load;

  // chain wiring
  cell_op_t              op;
  logic [COUNT_BITS-1:0] op_cnt;
  logic [IDX_W-1:0]      obj_w [MAX_RESIDENT];
  logic [COUNT_BITS-1:0] cnt_w [MAX_RESIDENT];
  logic [MAX_RESIDENT-1:0] le_w;
  logic [MAX_RESIDENT:0]   match_w;

  logic in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign idx_in     = IDX_W'(32'(in_tdata) % NUM_OBJECTS);
  assign cap_eff    = (32'(cap_r) > MAX_RESIDENT) ? TOT_W'(MAX_RESIDENT) : TOT_W'(cap_r);
  assign c_nxt      = (c_rd == CNT_MAX) ? c_rd : c_rd + 1'b1;
  assign op_cnt     = (state_r == ST_LOOK) ? c_nxt : c_r;
  assign out_load   = (state_r == ST_DONE) && (!out_vld_r || out_tready);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  fac_count_mem #(
    .DEPTH (NUM_OBJECTS),
    .IDX_W (IDX_W),
    .CNT_W (COUNT_BITS)
  ) u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (idx_in),
    .rd_data (c_rd),
    .wr_en   (state_r == ST_LOOK),
    .wr_addr (idx_r),
    .wr_data (c_nxt)
  );

  // ordered resident list, head at cell 0
  assign match_w[0] = 1'b0;
  for (genvar g = 0; g < MAX_RESIDENT; g++) begin : g_cell
    logic [IDX_W-1:0]      l_obj, r_obj;
    logic [COUNT_BITS-1:0] l_cnt, r_cnt;
    logic                  l_le, r_le;
    if (g == 0) begin : g_head
      assign l_obj = '0;
      assign l_cnt = '0;
      assign l_le  = 1'b0;
    end else begin : g_mid
      assign l_obj = obj_w[g-1];
      assign l_cnt = cnt_w[g-1];
      assign l_le  = le_w[g-1];
    end
    if (g == MAX_RESIDENT - 1) begin : g_tail
      assign r_obj = '0;
      assign r_cnt = '0;
      assign r_le  = 1'b0;
    end else begin : g_body
      assign r_obj = obj_w[g+1];
      assign r_cnt = cnt_w[g+1];
      assign r_le  = le_w[g+1];
    end
    fac_cell #(
      .IDX_W (IDX_W),
      .CNT_W (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .key       (idx_r),
      .key_cnt   (op_cnt),
      .vld       (TOT_W'(g) < total_r),
      .is_first  (g == 0),
      .left_obj  (l_obj),
      .left_cnt  (l_cnt),
      .left_le   (l_le),
      .right_obj (r_obj),
      .right_cnt (r_cnt),
      .right_le  (r_le),
      .match_in  (match_w[g]),
      .match_out (match_w[g+1]),
      .le        (le_w[g]),
      .obj       (obj_w[g]),
      .cnt       (cnt_w[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_LOOK;
      ST_LOOK: begin
        if (!flag_r[idx_r] && (c_nxt > COUNT_BITS'(1)) && !(total_r < cap_eff) &&
            (total_r != '0) && (cnt_w[0] < c_nxt)) begin
          state_nxt = ST_ADMIT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ADMIT: state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    op        = OP_NOP;
    total_nxt = total_r;
    flag_nxt  = flag_r;
    was_nxt   = was_r;
    adm_nxt   = adm_r;
    evc_nxt   = evc_r;
    vic_nxt   = vic_r;
    case (state_r)
      ST_LOOK: begin
        was_nxt = flag_r[idx_r];
        adm_nxt = 1'b0;
        evc_nxt = 1'b0;
        vic_nxt = '0;
        if (flag_r[idx_r]) begin
          op = OP_HIT;
        end else if (c_nxt > COUNT_BITS'(1)) begin
          if (total_r < cap_eff) begin
            op              = OP_INS;
            adm_nxt         = 1'b1;
            flag_nxt[idx_r] = 1'b1;
            total_nxt       = total_r + 1'b1;
          end else if ((total_r != '0) && (cnt_w[0] < c_nxt)) begin
            // evict the least requested; admission decided next cycle
            op                = OP_SHL;
            evc_nxt           = 1'b1;
            vic_nxt           = obj_w[0];
            flag_nxt[obj_w[0]] = 1'b0;
            total_nxt         = total_r - 1'b1;
          end
        end
      end
      ST_ADMIT: begin
        if (total_r < cap_eff) begin
          op              = OP_INS;
          adm_nxt         = 1'b1;
          flag_nxt[idx_r] = 1'b1;
          total_nxt       = total_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_tready) out_vld_nxt = 1'b0;
    if (out_load)   out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cap_r     <= CFG_W'(CAP_RESET);
      total_r   <= '0;
      flag_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      flag_r    <= flag_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    was_r <= was_nxt;
    adm_r <= adm_nxt;
    evc_r <= evc_nxt;
    vic_r <= vic_nxt;
    if (in_acc) idx_r <= idx_in;
    if (state_r == ST_LOOK) c_r <= c_nxt;
    if (out_load) begin
      out_data_r <= {6'b0, 7'(total_r), 16'(c_r), 8'(vic_r), evc_r, adm_r, was_r};
    end
  end

  `FAC_ASSERT(a_total_bound, total_r <= TOT_W'(MAX_RESIDENT), "resident total over limit")
  `FAC_ASSERT(a_accept_look, in_acc |=> state_r == ST_LOOK, "accept not followed by lookup")
  `FAC_ASSERT(a_admit_room, (state_r == ST_DONE && adm_r) |-> total_r <= cap_eff,
              "admission beyond capacity")
  `FAC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == ST_IDLE && !out_vld_r,
                     "reset did not idle the block")

endmodule
